@@ hdl/coma_pkg.sv @@
// Shared constants and types for the center-of-mass accumulator.
// No dependencies.
package coma_pkg;
    localparam int ATOM_TABLE_DEPTH = 4096;
    localparam int IDX_W = 12;
    localparam int ADDR_W = (ATOM_TABLE_DEPTH > 1) ? $clog2(ATOM_TABLE_DEPTH) : 1;
    localparam int MASS_W = 48;
    localparam int MOM_W = 64;
    localparam logic [MASS_W-1:0] MASS_MAX = {MASS_W{1'b1}};
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_MEMBER = 1'b1;
    localparam logic [0:0] REG_USE_WEIGHTS = 1'b0;

    typedef struct packed {
        logic [15:0] mass;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_atom;
endpackage

@@ hdl/center_of_mass_accumulator_core.sv @@
// Center-of-mass accumulator: atom table in one synchronous RAM, accumulators,
// and a radix-2 divider that produces the three center coordinates.
// Depends on coma_pkg.
// An in-range load is written to the table when accepted. A member passes accept, read,
// weight, multiply and accumulate steps; a last member then uses the single shared
// bit-serial divider per axis (one setup step, one iteration per quotient bit), or skips
// it for a zero total, and then an output step. One item is in flight at a time.
// Reset (synchronous, active low) clears the accumulators, flags and control; the atom
// table is not cleared; the user must load each entry before it is read (not enforced).
module center_of_mass_accumulator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [11:0] i_atom_index,
    input  logic [15:0] i_atom_mass,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [15:0] i_member_weight,
    input  logic        i_last_member,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [47:0] o_total_mass,
    output logic signed [31:0] o_com_x,
    output logic signed [31:0] o_com_y,
    output logic signed [31:0] o_com_z,
    output logic        o_zero_mass,
    output logic        o_saturated
);
    localparam int AW = coma_pkg::ADDR_W;
    localparam int MW = coma_pkg::MASS_W;
    localparam int XW = coma_pkg::MOM_W;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_WEIGHT, S_MUL, S_ACC, S_DIV, S_OUT
    } t_state;

    t_state r_state;
    logic r_use_weights;
    logic r_in_range, r_last;
    logic [15:0] r_weight;
    logic [coma_pkg::IDX_W-1:0] r_idx;

    coma_pkg::t_atom r_mem [coma_pkg::ATOM_TABLE_DEPTH];
    coma_pkg::t_atom r_rd;

    logic [17:0] r_m;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [XW-1:0] r_tx, r_ty, r_tz;
    logic [MW-1:0] r_mass_sum;
    logic signed [XW-1:0] r_mx, r_my, r_mz;
    logic r_sat;

    // divider
    logic [1:0] r_axis;
    logic [6:0] r_bit;
    logic [XW-1:0] r_rem, r_quo, r_num;
    logic r_neg;
    logic [31:0] r_cx, r_cy, r_cz;

    logic in_xfer, cfg_wr, in_range;
    logic [AW-1:0] rd_addr;
    logic [31:0] mul_wt;
    logic signed [XW-1:0] sx, sy, sz;
    logic ovf_any;
    logic [MW:0] mass_add;
    logic [XW:0] rem_sh;
    logic [XW-1:0] q_next;
    logic [31:0] com_v;
    logic signed [XW-1:0] mom_sel;
    logic [XW-1:0] mom_mag;

    assign pready = 1'b1;
    assign prdata = {31'd0, r_use_weights};
    assign cfg_wr = psel && penable && pwrite && (paddr == coma_pkg::REG_USE_WEIGHTS);
    assign o_stall = (r_state != S_IDLE);
    assign in_xfer = i_valid && !o_stall;
    assign in_range = ({20'd0, i_atom_index} < 32'(coma_pkg::ATOM_TABLE_DEPTH));
    // hold the read address on the accepted member while it is in flight
    assign rd_addr = (r_state == S_IDLE) ? i_atom_index[AW-1:0] : r_idx[AW-1:0];

    function automatic logic signed [XW-1:0] sat_add(input logic signed [XW-1:0] a,
                                                     input logic signed [XW-1:0] b,
                                                     output logic ov);
        logic signed [XW-1:0] s;
        s = a + b;
        ov = (a[XW-1] == b[XW-1]) && (s[XW-1] != a[XW-1]);
        if (ov) sat_add = a[XW-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
        else sat_add = s;
    endfunction

    always_comb begin
        logic ox, oy, oz;
        mul_wt = r_rd.mass * r_weight;
        mass_add = {1'b0, r_mass_sum} + {{(MW-17){1'b0}}, r_m};
        sx = sat_add(r_mx, r_tx, ox);
        sy = sat_add(r_my, r_ty, oy);
        sz = sat_add(r_mz, r_tz, oz);
        ovf_any = ox || oy || oz;
        case (r_axis)
            2'd0: mom_sel = r_mx;
            2'd1: mom_sel = r_my;
            default: mom_sel = r_mz;
        endcase
        mom_mag = mom_sel[XW-1] ? (~mom_sel + 64'd1) : mom_sel;
        rem_sh = {r_rem, r_num[XW-1]};
        q_next = {r_quo[XW-2:0], 1'b0};
        if (rem_sh >= {{(XW-MW+1){1'b0}}, r_mass_sum}) q_next[0] = 1'b1;
        if (r_neg) com_v = (q_next > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q_next);
        else com_v = (q_next > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_next[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_action == coma_pkg::ACT_LOAD && in_range)
            r_mem[i_atom_index[AW-1:0]] <= '{i_atom_mass, i_pos_x, i_pos_y, i_pos_z};
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_use_weights <= 1'b0;
            r_mass_sum <= '0;
            r_mx <= '0; r_my <= '0; r_mz <= '0;
            r_sat <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (cfg_wr) r_use_weights <= pwdata[0];
            case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_action == coma_pkg::ACT_MEMBER) begin
                        r_state <= S_READ;
                        r_in_range <= in_range;
                        r_last <= i_last_member;
                        r_weight <= i_member_weight;
                        r_idx <= i_atom_index;
                    end
                end
                S_READ: begin
                    // table data registered this cycle
                    r_state <= S_WEIGHT;
                end
                S_WEIGHT: begin
                    if (!r_in_range) begin
                        r_m <= '0; r_px <= '0; r_py <= '0; r_pz <= '0;
                    end else begin
                        r_m <= r_use_weights ? mul_wt[31:14] : {2'b00, r_rd.mass};
                        r_px <= r_rd.x; r_py <= r_rd.y; r_pz <= r_rd.z;
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_tx <= XW'($signed({1'b0, r_m}) * r_px);
                    r_ty <= XW'($signed({1'b0, r_m}) * r_py);
                    r_tz <= XW'($signed({1'b0, r_m}) * r_pz);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (mass_add[MW]) r_mass_sum <= coma_pkg::MASS_MAX;
                    else r_mass_sum <= mass_add[MW-1:0];
                    r_mx <= sx; r_my <= sy; r_mz <= sz;
                    r_sat <= r_sat || mass_add[MW] || ovf_any;
                    if (r_last) begin
                        r_state <= S_DIV;
                        r_axis <= 2'd0;
                        r_bit <= 7'd0;
                    end else r_state <= S_IDLE;
                end
                S_DIV: begin
                    if (r_mass_sum == '0) begin
                        r_cx <= '0; r_cy <= '0; r_cz <= '0;
                        r_state <= S_OUT;
                        o_valid <= 1'b1;
                    end else if (r_bit == 7'd0) begin
                        r_num <= mom_mag;
                        r_neg <= mom_sel[XW-1];
                        r_rem <= '0;
                        r_quo <= '0;
                        r_bit <= 7'd1;
                    end else begin
                        r_num <= {r_num[XW-2:0], 1'b0};
                        r_quo <= q_next;
                        r_rem <= q_next[0] ? XW'(rem_sh - {{(XW-MW+1){1'b0}}, r_mass_sum})
                                           : rem_sh[XW-1:0];
                        if (r_bit == 7'd64) begin
                            r_bit <= 7'd0;
                            case (r_axis)
                                2'd0: r_cx <= com_v;
                                2'd1: r_cy <= com_v;
                                default: r_cz <= com_v;
                            endcase
                            if (r_axis == 2'd2) begin
                                r_state <= S_OUT;
                                o_valid <= 1'b1;
                            end else r_axis <= r_axis + 2'd1;
                        end else r_bit <= r_bit + 7'd1;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_mass_sum <= '0;
                        r_mx <= '0; r_my <= '0; r_mz <= '0;
                        r_sat <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_total_mass = r_mass_sum;
    assign o_com_x = r_cx;
    assign o_com_y = r_cy;
    assign o_com_z = r_cz;
    assign o_zero_mass = (r_mass_sum == '0);
    assign o_saturated = r_sat;

    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("result valid outside output state");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall) else $error("input taken while busy");
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_mass) |-> (o_com_x == 0 && o_com_y == 0 && o_com_z == 0))
        else $error("zero mass with nonzero center");
    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> (r_mass_sum == '0 && !r_sat))
        else $error("accumulators not cleared after result");
endmodule
